// ===== hdl/key_short_long_press_detector_core_defines.svh =====
// Assertion macros for the key short/long press detector core.
// Used by key_short_long_press_detector_core.sv; expects signals clock and reset in scope.
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_CORE_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KSLPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kslpd_pkg.sv =====
// Shared constants and codes for the key short/long press detector core.
// No dependencies; used by key_short_long_press_detector_core.sv.
package kslpd_pkg;

   localparam int IN_BITS             = 5;   // key lines carried on the ports
   localparam int NUM_KEYS_DEF        = 5;
   localparam int HOLD_TIME_BITS_DEF  = 16;
   localparam int LONG_BITS           = 16;
   localparam int WAIT_BITS           = 8;
   localparam int CSR_DATA_BITS       = 16;
   localparam int CSR_INDEX_BITS      = 1;

   localparam logic [LONG_BITS-1:0] LONG_PRESS_RESET    = 16'd200;
   localparam logic [WAIT_BITS-1:0] SCAN_INTERVAL_RESET = 8'd10;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_EDGE = 2'd1,
      MODE_SCAN = 2'd2,
      MODE_ACK  = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LONG_PRESS_TICKS    = 1'b0,
      CSR_SCAN_INTERVAL_TICKS = 1'b1
   } csr_index_type;

endpackage

// ===== hdl/key_short_long_press_detector_core.sv =====
// Short/long press classifier for active-low keys. Every accepted item (tick, falling-edge
// event, scan poll or acknowledge) updates the key state in the cycle it is accepted (a scan
// poll only once armed and past the scan interval) and loads one result into the output
// register, so one item is taken per clock while the input is not stalled. The input side
// stalls only while a result waits in the output register and the output is stalled.
// Configuration writes take effect at the next clock and should be made while idle.
// Depends on kslpd_pkg and key_short_long_press_detector_core_defines.svh.
`include "key_short_long_press_detector_core_defines.svh"

module key_short_long_press_detector_core #(
   parameter int NUM_KEYS       = kslpd_pkg::NUM_KEYS_DEF,
   parameter int HOLD_TIME_BITS = kslpd_pkg::HOLD_TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wen,
   input  logic [kslpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kslpd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic [kslpd_pkg::IN_BITS-1:0]         req_key_levels,
   input  logic [kslpd_pkg::IN_BITS-1:0]         req_edge_keys,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [kslpd_pkg::IN_BITS-1:0]         rsp_short_pressed,
   output logic [kslpd_pkg::IN_BITS-1:0]         rsp_long_pressed,
   output logic [kslpd_pkg::IN_BITS-1:0]         rsp_long_pressing,
   output logic                                  rsp_value_changed,
   output logic                                  rsp_press_armed
);

   localparam int IN_BITS   = kslpd_pkg::IN_BITS;
   localparam int LONG_BITS = kslpd_pkg::LONG_BITS;
   localparam int WAIT_BITS = kslpd_pkg::WAIT_BITS;
   localparam int CMP_BITS  = (HOLD_TIME_BITS > LONG_BITS) ? HOLD_TIME_BITS : LONG_BITS;

   // configuration registers
   logic [LONG_BITS-1:0]      long_press_ff, long_press_in;
   logic [WAIT_BITS-1:0]      scan_interval_ff, scan_interval_in;

   // key state
   logic [NUM_KEYS-1:0]       held_ff, held_in;
   logic [HOLD_TIME_BITS-1:0] hold_ff [NUM_KEYS];
   logic [HOLD_TIME_BITS-1:0] hold_in [NUM_KEYS];
   logic [NUM_KEYS-1:0]       long_hold_ff, long_hold_in;
   logic [NUM_KEYS-1:0]       short_ff, short_in;
   logic [NUM_KEYS-1:0]       long_ff, long_in;
   logic                      armed_ff, armed_in;
   logic                      changed_ff, changed_in;
   logic [WAIT_BITS-1:0]      scan_wait_ff, scan_wait_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IN_BITS-1:0]        rsp_short_ff, rsp_short_in;
   logic [IN_BITS-1:0]        rsp_long_ff, rsp_long_in;
   logic [IN_BITS-1:0]        rsp_lhold_ff, rsp_lhold_in;
   logic                      rsp_changed_ff;
   logic                      rsp_armed_ff;

   kslpd_pkg::mode_type       mode;
   logic                      req_accept;
   logic                      scan_go;
   logic                      release_any;
   logic [NUM_KEYS-1:0]       key_low;
   logic [NUM_KEYS-1:0]       key_edge;
   logic [NUM_KEYS-1:0]       at_long;

   assign mode       = kslpd_pkg::mode_type'(req_mode);
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign scan_go    = armed_ff && (scan_wait_ff > scan_interval_ff);

   // Keys past the port width read as released with no edge; keys past NUM_KEYS read as zero.
   for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key_in
      if (i < IN_BITS) begin : g_wired
         assign key_low[i]  = ~req_key_levels[i];
         assign key_edge[i] = req_edge_keys[i];
      end else begin : g_unwired
         assign key_low[i]  = 1'b0;
         assign key_edge[i] = 1'b0;
      end
      assign at_long[i] = CMP_BITS'(hold_ff[i]) >= CMP_BITS'(long_press_ff);
   end

   for (genvar j = 0; j < IN_BITS; j++) begin : g_rsp_bit
      if (j < NUM_KEYS) begin : g_key
         assign rsp_short_in[j] = short_in[j];
         assign rsp_long_in[j]  = long_in[j];
         assign rsp_lhold_in[j] = long_hold_in[j];
      end else begin : g_none
         assign rsp_short_in[j] = 1'b0;
         assign rsp_long_in[j]  = 1'b0;
         assign rsp_lhold_in[j] = 1'b0;
      end
   end

   always_comb begin
      long_press_in    = long_press_ff;
      scan_interval_in = scan_interval_ff;
      if (csr_wen) begin
         unique case (kslpd_pkg::csr_index_type'(csr_index))
            kslpd_pkg::CSR_LONG_PRESS_TICKS: begin
               long_press_in = csr_wdata[LONG_BITS-1:0];
            end
            kslpd_pkg::CSR_SCAN_INTERVAL_TICKS: begin
               scan_interval_in = csr_wdata[WAIT_BITS-1:0];
            end
            default: begin
               long_press_in = long_press_ff;
            end
         endcase
      end
   end

   always_comb begin
      held_in      = held_ff;
      hold_in      = hold_ff;
      long_hold_in = long_hold_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      armed_in     = armed_ff;
      changed_in   = changed_ff;
      scan_wait_in = scan_wait_ff;
      release_any  = 1'b0;
      if (req_accept) begin
         unique case (mode)
            kslpd_pkg::MODE_TICK: begin
               for (int i = 0; i < NUM_KEYS; i++) begin
                  if (held_ff[i] && !(&hold_ff[i])) begin
                     hold_in[i] = hold_ff[i] + HOLD_TIME_BITS'(1);
                  end
               end
               if (!(&scan_wait_ff)) begin
                  scan_wait_in = scan_wait_ff + WAIT_BITS'(1);
               end
            end
            kslpd_pkg::MODE_EDGE: begin
               if (|(key_low & key_edge)) begin
                  armed_in = 1'b1;
               end
            end
            kslpd_pkg::MODE_SCAN: begin
               if (scan_go) begin
                  for (int i = 0; i < NUM_KEYS; i++) begin
                     if (key_low[i]) begin
                        if (!held_ff[i]) begin
                           held_in[i] = 1'b1;
                           hold_in[i] = '0;
                        end else if (at_long[i]) begin
                           long_hold_in[i] = 1'b1;
                        end
                     end else if (held_ff[i]) begin
                        // classify the release
                        held_in[i]      = 1'b0;
                        long_hold_in[i] = 1'b0;
                        long_in[i]      = at_long[i];
                        short_in[i]     = ~at_long[i];
                        release_any     = 1'b1;
                     end
                  end
                  scan_wait_in = '0;
                  if (release_any) begin
                     armed_in   = 1'b0;
                     changed_in = 1'b1;
                  end
               end
            end
            kslpd_pkg::MODE_ACK: begin
               changed_in = 1'b0;
            end
            default: begin
               changed_in = changed_ff;
            end
         endcase
      end
   end

   // Hold a stalled result; drop it once transferred unless a new item replaces it.
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff    <= kslpd_pkg::LONG_PRESS_RESET;
         scan_interval_ff <= kslpd_pkg::SCAN_INTERVAL_RESET;
         held_ff          <= '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            hold_ff[i] <= '0;
         end
         long_hold_ff     <= '0;
         short_ff         <= '0;
         long_ff          <= '0;
         armed_ff         <= 1'b0;
         changed_ff       <= 1'b0;
         scan_wait_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         long_press_ff    <= long_press_in;
         scan_interval_ff <= scan_interval_in;
         held_ff          <= held_in;
         hold_ff          <= hold_in;
         long_hold_ff     <= long_hold_in;
         short_ff         <= short_in;
         long_ff          <= long_in;
         armed_ff         <= armed_in;
         changed_ff       <= changed_in;
         scan_wait_ff     <= scan_wait_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_short_ff   <= rsp_short_in;
         rsp_long_ff    <= rsp_long_in;
         rsp_lhold_ff   <= rsp_lhold_in;
         rsp_changed_ff <= changed_in;
         rsp_armed_ff   <= armed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_short_pressed = rsp_short_ff;
   assign rsp_long_pressed  = rsp_long_ff;
   assign rsp_long_pressing = rsp_lhold_ff;
   assign rsp_value_changed = rsp_changed_ff;
   assign rsp_press_armed   = rsp_armed_ff;

   `KSLPD_ASSERT_NOW(a_result_exclusive, 1'b1, (short_ff & long_ff) == '0, "short and long both set")
   `KSLPD_ASSERT_NOW(a_long_needs_held, 1'b1, (long_hold_ff & ~held_ff) == '0, "long flag on released key")
   `KSLPD_ASSERT_NEXT(a_accept_gives_rsp, req_accept, rsp_valid_ff, "accepted item gave no result")
   `KSLPD_ASSERT_NEXT(a_ack_clears, req_accept && (mode == kslpd_pkg::MODE_ACK), !changed_ff, "ack did not clear")
   `KSLPD_ASSERT_NEXT(a_scan_restarts, req_accept && (mode == kslpd_pkg::MODE_SCAN) && scan_go, scan_wait_ff == '0, "scan did not restart interval")

endmodule
